### hdl/i2c_master_bit_engine_macros.svh
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shared concurrent assertion forms; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Same-cycle implication.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared constants, codes and structs.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TX_DEPTH = 16;
    localparam int TX_IDX_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    // wide enough to hold TX_DEPTH up to 256
    localparam int LEN_W    = 9;

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_ADDRESS,
        PH_WRITE,
        PH_READ,
        PH_SLAVE_ACK,
        PH_MASTER_ACK,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START_WR,
        CMD_START_RD,
        CMD_LOAD
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SLAVE_ADDRESS,
        REG_WRITE_LENGTH,
        REG_READ_LENGTH
    } reg_idx_t;

    typedef struct packed {
        logic [6:0]       slave_address;
        logic [LEN_W-1:0] write_len;     // effective, 1..TX_DEPTH
        logic [7:0]       read_len;      // effective, 1..255
    } cfg_t;

    typedef struct packed {
        logic [1:0] command;
        logic       sda_in;
        logic [3:0] load_index;
        logic [7:0] load_value;
    } req_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       nack_seen;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
    } res_t;

    typedef struct packed {
        logic                en;
        logic [TX_IDX_W-1:0] idx;
        logic [7:0]          data;
    } tx_wr_t;

endpackage

### hdl/i2cm_ifs.sv
// ----------------------------------------------------------------------------
// I2C master bit engine channels
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       sda_in;
    logic [3:0] load_index;
    logic [7:0] load_value;

    modport source (output valid, command, sda_in, load_index, load_value, input ready);
    modport sink   (input valid, command, sda_in, load_index, load_value, output ready);
endinterface

interface i2cm_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       nack_seen;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;

    modport source (output valid, scl_out, sda_out, busy_res, nack_seen, rx_valid, rx_byte,
                    rx_index, input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, nack_seen, rx_valid, rx_byte,
                    rx_index, output ready);
endinterface

### hdl/i2cm_regs.sv
// ----------------------------------------------------------------------------
// I2C master configuration registers
// APB-style register file; presents clamped transfer lengths.
// ----------------------------------------------------------------------------
module i2cm_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0]   paddr,
    input  logic [i2cm_pkg::PDATA_W-1:0]   pwdata,
    output logic [i2cm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output i2cm_pkg::cfg_t                 cfg
);
    import i2cm_pkg::*;

    logic [6:0]       slave_address_reg;
    logic [4:0]       write_length_reg;
    logic [7:0]       read_length_reg;
    logic             wr_en;
    reg_idx_t         reg_idx;
    logic [LEN_W-1:0] wlen_ext;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 7'd0;
            write_length_reg  <= 5'd1;
            read_length_reg   <= 8'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SLAVE_ADDRESS: slave_address_reg <= pwdata[6:0];
                REG_WRITE_LENGTH:  write_length_reg  <= pwdata[4:0];
                REG_READ_LENGTH:   read_length_reg   <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SLAVE_ADDRESS: prdata = PDATA_W'(slave_address_reg);
            REG_WRITE_LENGTH:  prdata = PDATA_W'(write_length_reg);
            REG_READ_LENGTH:   prdata = PDATA_W'(read_length_reg);
            default:           prdata = '0;
        endcase
    end

    // zero acts as one; write length capped at buffer depth
    assign wlen_ext = LEN_W'(write_length_reg);

    always_comb
    begin
        cfg.slave_address = slave_address_reg;
        if (wlen_ext == '0)
            cfg.write_len = LEN_W'(1);
        else if (wlen_ext > LEN_W'(TX_DEPTH))
            cfg.write_len = LEN_W'(TX_DEPTH);
        else
            cfg.write_len = wlen_ext;
        cfg.read_len = (read_length_reg == 8'd0) ? 8'd1 : read_length_reg;
    end

endmodule

### hdl/i2cm_txbuf.sv
// ----------------------------------------------------------------------------
// I2C master transmit buffer
// Byte slots loaded while idle, read at the current byte count.
// ----------------------------------------------------------------------------
module i2cm_txbuf (
    input  logic                            clk,
    input  i2cm_pkg::tx_wr_t                wr,
    input  logic [i2cm_pkg::TX_IDX_W-1:0]   rd_idx,
    output logic [7:0]                      rd_data
);
    import i2cm_pkg::*;

    logic [7:0] buf_reg [TX_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
            buf_reg[wr.idx] <= wr.data;
    end

    assign rd_data = buf_reg[rd_idx];

endmodule

### hdl/i2cm_core.sv
// ----------------------------------------------------------------------------
// I2C master half-bit state machine
// Bus state register and the one-tick phase transition.
// ----------------------------------------------------------------------------
module i2cm_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  i2cm_pkg::req_t                  item,
    input  i2cm_pkg::cfg_t                  cfg,
    input  logic [7:0]                      tx_data,
    output logic [i2cm_pkg::TX_IDX_W-1:0]   tx_rd_idx,
    output i2cm_pkg::tx_wr_t                tx_wr,
    output i2cm_pkg::res_t                  res
);
    import i2cm_pkg::*;

    phase_t     phase_reg,      phase_next;
    logic       clock_high_reg, clock_high_next;
    logic [3:0] bit_count_reg,  bit_count_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic       reading_reg,    reading_next;
    logic       writing_reg,    writing_next;
    logic [7:0] addr_dir_reg,   addr_dir_next;
    logic [7:0] rx_shift_reg,   rx_shift_next;
    logic       sda_reg,        sda_next;
    logic       nack_reg,       nack_next;

    cmd_t       cmd;
    logic       is_idle;
    logic       tx_in_range;
    logic       load_in_range;
    logic [7:0] send_byte;
    logic [3:0] bit_inc;
    logic [7:0] byte_inc;
    logic [7:0] byte_sat;
    logic [7:0] shift_in;
    logic       last_read;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;

    assign cmd           = cmd_t'(item.command);
    assign is_idle       = (phase_reg == PH_IDLE);
    assign tx_rd_idx     = TX_IDX_W'(byte_count_reg);
    assign tx_in_range   = LEN_W'(byte_count_reg) < LEN_W'(TX_DEPTH);
    assign load_in_range = LEN_W'(item.load_index) < LEN_W'(TX_DEPTH);
    assign send_byte     = (phase_reg == PH_ADDRESS) ? addr_dir_reg :
                           (tx_in_range ? tx_data : 8'd0);
    assign bit_inc       = bit_count_reg + 4'd1;
    assign byte_inc      = byte_count_reg + 8'd1;
    assign byte_sat      = (byte_count_reg < 8'hFF) ? byte_inc : byte_count_reg;
    assign shift_in      = {rx_shift_reg[6:0], item.sda_in};
    assign last_read     = byte_sat >= cfg.read_len;

    assign tx_wr.en   = fire && (cmd == CMD_LOAD) && is_idle && load_in_range;
    assign tx_wr.idx  = TX_IDX_W'(item.load_index);
    assign tx_wr.data = item.load_value;

    always_comb
    begin
        phase_next      = phase_reg;
        clock_high_next = clock_high_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        reading_next    = reading_reg;
        writing_next    = writing_reg;
        addr_dir_next   = addr_dir_reg;
        rx_shift_next   = rx_shift_reg;
        sda_next        = sda_reg;
        nack_next       = nack_reg;
        rx_valid        = 1'b0;
        rx_byte         = 8'd0;
        rx_index        = 8'd0;

        unique case (cmd)
            CMD_START_WR, CMD_START_RD:
            begin
                if (is_idle)
                begin
                    addr_dir_next   = {cfg.slave_address, (cmd == CMD_START_RD)};
                    bit_count_next  = 4'd0;
                    byte_count_next = 8'd0;
                    rx_shift_next   = 8'd0;
                    nack_next       = 1'b0;
                    reading_next    = (cmd == CMD_START_RD);
                    writing_next    = (cmd == CMD_START_WR);
                    phase_next      = PH_START;
                end
            end
            CMD_LOAD:
            begin
                // buffer write only, bus untouched
            end
            CMD_TICK:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_START:
                    begin
                        if (clock_high_reg)
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_ADDRESS;
                        end
                        else
                            clock_high_next = 1'b1;
                    end
                    PH_ADDRESS, PH_WRITE:
                    begin
                        if (clock_high_reg)
                        begin
                            clock_high_next = 1'b0;
                            if (bit_count_reg == 4'd8)
                            begin
                                bit_count_next = 4'd0;
                                if (phase_reg == PH_WRITE)
                                begin
                                    byte_count_next = byte_inc;
                                    if (LEN_W'(byte_inc) >= cfg.write_len)
                                        writing_next = 1'b0;
                                end
                                sda_next   = 1'b1;
                                phase_next = PH_SLAVE_ACK;
                            end
                        end
                        else
                        begin
                            // MSB first
                            sda_next        = send_byte[~bit_count_reg[2:0]];
                            clock_high_next = 1'b1;
                            bit_count_next  = bit_inc;
                        end
                    end
                    PH_READ:
                    begin
                        if (clock_high_reg)
                        begin
                            rx_shift_next   = shift_in;
                            clock_high_next = 1'b0;
                            bit_count_next  = bit_inc;
                            if (bit_inc >= 4'd8)
                            begin
                                rx_valid        = 1'b1;
                                rx_byte         = shift_in;
                                rx_index        = byte_count_reg;
                                rx_shift_next   = 8'd0;
                                bit_count_next  = 4'd0;
                                byte_count_next = byte_sat;
                                if (last_read)
                                    reading_next = 1'b0;
                                // ACK low, NACK on the last byte
                                sda_next   = last_read;
                                phase_next = PH_MASTER_ACK;
                            end
                        end
                        else
                        begin
                            sda_next        = 1'b1;
                            clock_high_next = 1'b1;
                        end
                    end
                    PH_SLAVE_ACK:
                    begin
                        bit_count_next = 4'd0;
                        if (clock_high_reg)
                        begin
                            clock_high_next = 1'b0;
                            if (item.sda_in)
                            begin
                                nack_next    = 1'b1;
                                sda_next     = 1'b0;
                                reading_next = 1'b0;
                                writing_next = 1'b0;
                                phase_next   = PH_STOP;
                            end
                            else if (reading_reg)
                                phase_next = PH_READ;
                            else if (writing_reg)
                                phase_next = PH_WRITE;
                            else
                            begin
                                sda_next   = 1'b0;
                                phase_next = PH_STOP;
                            end
                        end
                        else
                            clock_high_next = 1'b1;
                    end
                    PH_MASTER_ACK:
                    begin
                        if (clock_high_reg)
                        begin
                            clock_high_next = 1'b0;
                            if (reading_reg)
                            begin
                                sda_next   = 1'b1;
                                phase_next = PH_READ;
                            end
                            else
                            begin
                                sda_next   = 1'b0;
                                phase_next = PH_STOP;
                            end
                        end
                        else
                            clock_high_next = 1'b1;
                    end
                    PH_STOP:
                    begin
                        if (clock_high_reg)
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            clock_high_next = 1'b1;
                            sda_next        = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            clock_high_reg <= 1'b1;
            bit_count_reg  <= 4'd0;
            byte_count_reg <= 8'd0;
            reading_reg    <= 1'b0;
            writing_reg    <= 1'b0;
            addr_dir_reg   <= 8'd0;
            rx_shift_reg   <= 8'd0;
            sda_reg        <= 1'b1;
            nack_reg       <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            clock_high_reg <= clock_high_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            reading_reg    <= reading_next;
            writing_reg    <= writing_next;
            addr_dir_reg   <= addr_dir_next;
            rx_shift_reg   <= rx_shift_next;
            sda_reg        <= sda_next;
            nack_reg       <= nack_next;
        end
    end

    always_comb
    begin
        res.scl_out   = clock_high_next;
        res.sda_out   = sda_next;
        res.busy_res  = (phase_next != PH_IDLE);
        res.nack_seen = nack_next;
        res.rx_valid  = rx_valid;
        res.rx_byte   = rx_byte;
        res.rx_index  = rx_index;
    end

endmodule

### hdl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// I2C master bit engine (seven-bit addressing), top level
// Path: an accepted command transaction passes the input register, then the result register.
// Throughput: 1 transaction per cycle while the result channel is not stalled; the half-bit
//   state update is one registered step between the input register and the result register.
// Reset: rst_n asynchronous, active low; bus released, idle, registers at
//   defaults; the transmit buffer holds no data until loaded.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    i2cm_req_if.sink                       req,
    i2cm_rsp_if.source                     rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0]   paddr,
    input  logic [i2cm_pkg::PDATA_W-1:0]   pwdata,
    output logic [i2cm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import i2cm_pkg::*;

    // Two-stage pipeline:
    //   stage 1 - input register, holds one accepted command transaction
    //   stage 2 - result register, holds one finished result
    // The state machine advances when stage 1 moves into stage 2, so a new
    // transaction is taken every cycle while results drain, and a stalled
    // result does not block the input until stage 1 is also full.

    logic    s1_valid_reg,  s1_valid_next;
    req_t    s1_item_reg,   s1_item_next;
    logic    out_valid_reg, out_valid_next;
    res_t    out_res_reg;

    logic    in_acc;
    logic    s1_go;
    cfg_t    cfg;
    res_t    core_res;
    tx_wr_t  tx_wr;
    logic    [TX_IDX_W-1:0] tx_rd_idx;
    logic    [7:0]          tx_data;

    // stage 1 hands over whenever the result slot is free or being emptied
    assign s1_go     = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_go;
    assign in_acc    = req.valid && req.ready;

    assign s1_valid_next  = in_acc || (s1_valid_reg && !s1_go);
    assign out_valid_next = s1_go || (out_valid_reg && !rsp.ready);

    always_comb
    begin
        s1_item_next.command    = req.command;
        s1_item_next.sda_in     = req.sda_in;
        s1_item_next.load_index = req.load_index;
        s1_item_next.load_value = req.load_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
            s1_item_reg <= s1_item_next;
        if (s1_go)
            out_res_reg <= core_res;
    end

    // configuration registers; the user must write them only while the engine is quiet, not enforced here
    i2cm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // transmit bytes, loaded by the load command while idle
    i2cm_txbuf u_txbuf (
        .clk     (clk),
        .wr      (tx_wr),
        .rd_idx  (tx_rd_idx),
        .rd_data (tx_data)
    );

    // half-bit phase state machine, advanced once per stage-1 handover
    i2cm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_go),
        .item      (s1_item_reg),
        .cfg       (cfg),
        .tx_data   (tx_data),
        .tx_rd_idx (tx_rd_idx),
        .tx_wr     (tx_wr),
        .res       (core_res)
    );

    // result channel driven straight from the result register
    assign rsp.valid     = out_valid_reg;
    assign rsp.scl_out   = out_res_reg.scl_out;
    assign rsp.sda_out   = out_res_reg.sda_out;
    assign rsp.busy_res  = out_res_reg.busy_res;
    assign rsp.nack_seen = out_res_reg.nack_seen;
    assign rsp.rx_valid  = out_res_reg.rx_valid;
    assign rsp.rx_byte   = out_res_reg.rx_byte;
    assign rsp.rx_index  = out_res_reg.rx_index;

endmodule

### hdl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_macros.svh"

module i2cm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       scl_out,
    input logic       sda_out,
    input logic       busy_res,
    input logic       nack_seen,
    input logic       rx_valid,
    input logic [7:0] rx_byte,
    input logic [7:0] rx_index
);

    // stalled result transaction holds
    `I2CM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({scl_out, sda_out, busy_res, nack_seen, rx_valid, rx_byte, rx_index}), "result changed while stalled")

    // bus is released whenever no transfer is running
    `I2CM_ASSERT_NOW(a_idle_released, rsp_valid && !busy_res, scl_out && sda_out, "bus not released while idle")

    // a received byte always leaves the engine in its acknowledge slot
    `I2CM_ASSERT_NOW(a_rx_busy, rsp_valid && rx_valid, busy_res && !scl_out, "received byte outside a transfer")

    // no stray receive data
    `I2CM_ASSERT_NOW(a_rx_zero, rsp_valid && !rx_valid, (rx_byte == 8'd0) && (rx_index == 8'd0), "receive fields set without a byte")

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .scl_out   (rsp.scl_out),
    .sda_out   (rsp.sda_out),
    .busy_res  (rsp.busy_res),
    .nack_seen (rsp.nack_seen),
    .rx_valid  (rsp.rx_valid),
    .rx_byte   (rsp.rx_byte),
    .rx_index  (rsp.rx_index)
);
